// ----- design/fir_q15_pkg.sv -----
// Shared types, constants and functions for the Q15 FIR filter.
// Holds the half coefficient table, the 16-bit clamp and the tap control word.
// No dependencies.
package fir_q15_pkg;

	localparam int ROM_LEN    = 401;
	localparam int ROM_MID    = 200;
	localparam int COEF_IDX_W = 10;

	typedef logic [15:0] word_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic live;
	} tap_ctl_t;

	localparam word_t COEF_HALF [0:ROM_MID] = '{
		16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
		16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
		16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
		16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
		16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
		16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFE, 16'hFFFE,
		16'h0000, 16'h0001, 16'hFFFF, 16'hFFFE, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
		16'h0000, 16'h0000, 16'hFFFE, 16'hFFFE, 16'h0001, 16'h0003, 16'hFFFF, 16'hFFFB,
		16'hFFFD, 16'h0003, 16'h0004, 16'hFFFE, 16'hFFFB, 16'hFFFF, 16'h0001, 16'h0000,
		16'h0000, 16'h0002, 16'h0000, 16'hFFF9, 16'hFFFB, 16'h0007, 16'h000A, 16'hFFFC,
		16'hFFF2, 16'hFFFC, 16'h000B, 16'h0008, 16'hFFFA, 16'hFFF7, 16'h0000, 16'h0002,
		16'hFFFF, 16'h0004, 16'h0009, 16'hFFFC, 16'hFFEC, 16'hFFFA, 16'h0017, 16'h0014,
		16'hFFF0, 16'hFFE1, 16'h0000, 16'h001B, 16'h000C, 16'hFFF1, 16'hFFF4, 16'h0001,
		16'hFFFD, 16'hFFFC, 16'h0012, 16'h0016, 16'hFFEB, 16'hFFD0, 16'h0000, 16'h003B,
		16'h001F, 16'hFFD1, 16'hFFC9, 16'h000F, 16'h0033, 16'h000A, 16'hFFE7, 16'hFFF7,
		16'hFFFE, 16'hFFEA, 16'h0000, 16'h003A, 16'h0026, 16'hFFBD, 16'hFFA3, 16'h001F,
		16'h007B, 16'h001F, 16'hFF97, 16'hFFB1, 16'h0031, 16'h004A, 16'hFFFF, 16'hFFE7,
		16'h0003, 16'hFFE3, 16'hFFBF, 16'h001C, 16'h008D, 16'h002B, 16'hFF56, 16'hFF6A,
		16'h0070, 16'h00D9, 16'hFFFE, 16'hFF3B, 16'hFFA8, 16'h0065, 16'h0055, 16'hFFF2,
		16'h0008, 16'h0011, 16'hFF8E, 16'hFF78, 16'h007E, 16'h0125, 16'hFFFE, 16'hFE8E,
		16'hFF38, 16'h0122, 16'h0158, 16'hFF9E, 16'hFEBA, 16'hFFBC, 16'h00A1, 16'h0041,
		16'h0004, 16'h0076, 16'hFFFF, 16'hFEA6, 16'hFF15, 16'h0199, 16'h0242, 16'hFF3E,
		16'hFCE7, 16'hFF2E, 16'h02BB, 16'h021A, 16'hFEA8, 16'hFDDD, 16'h0000, 16'h00D2,
		16'hFFFA, 16'h00C1, 16'h01E7, 16'hFF1B, 16'hFB46, 16'hFE6F, 16'h066F, 16'h0632,
		16'hFAF3, 16'hF511, 16'h0001, 16'h0D03, 16'h0729, 16'hF55E, 16'hF28B, 16'h041A,
		16'h0FF4
	};

	// Mirror the half table; taps past the table end get zero.
	function automatic word_t coef_at(input logic [COEF_IDX_W-1:0] j);
		logic [7:0] k;
		k = '0;
		if (j > COEF_IDX_W'(ROM_LEN - 1)) begin
			return '0;
		end
		if (j <= COEF_IDX_W'(ROM_MID)) begin
			k = j[7:0];
		end else begin
			k = 8'((ROM_LEN - 1) - int'(j));
		end
		return COEF_HALF[k];
	endfunction

	// Clamp a 17-bit signed value to 16 bits.
	function automatic word_t sat16(input logic [16:0] v);
		if (v[16] != v[15]) begin
			return v[16] ? 16'h8000 : 16'h7FFF;
		end
		return v[15:0];
	endfunction

endpackage

// ----- design/fir_filter_q15_saturating.sv -----
// Top level of the 401-tap Q15 FIR filter with per-tap saturating accumulate.
// Depends on fir_q15_pkg, fir_q15_dly, fir_q15_seq and fir_q15_mac.
//
//   channel | ports                                 | word
//   input   | in_valid, in_stall, sample_in         | one signed Q15 sample
//   output  | out_valid, out_stall,                 | raw sample and filter result
//           | passthrough_sample, filtered_sample   |
//
// Words are taken one at a time, only in the idle state. Each word goes through one
// delay memory read per tap through the single read port, then the shared
// multiply-accumulate unit and the load of the output register; the filter then
// returns to idle, in which the next word is taken.
// in_stall is high from acceptance until the result sits in the output register.
// A result that finds the output word still held by out_stall waits, with
// in_stall high, until that word is taken.
// After reset the delay line reads as zeros; there is no clearing pass.
module fir_filter_q15_saturating #(
	parameter int TAPS = 401
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] sample_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] passthrough_sample,
	output logic [15:0] filtered_sample
);
	import fir_q15_pkg::*;

	localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_HOLD = 4'b1000
	} state_t;

	state_t        state_q;
	logic [AW-1:0] pos_q;
	logic [AW:0]   fill_q;
	word_t         sample_q;
	logic          out_valid_q;
	word_t         out_pass_q;
	word_t         out_filt_q;

	logic          accept;
	logic          out_free;
	logic          load_out;
	logic          seq_busy;
	logic          last_issued;
	logic [AW-1:0] rd_addr;
	logic          rd_en;
	tap_ctl_t      ctl_s1;
	word_t         coef_s1;
	word_t         rd_data;
	word_t         acc;
	logic          acc_done;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign load_out = out_free && ((state_q == ST_HOLD) || (state_q == ST_WAIT && acc_done));

	fir_q15_dly #(
		.DEPTH (TAPS),
		.AW    (AW)
	) u_dly (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (pos_q),
		.wr_data (sample_in),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	fir_q15_seq #(
		.TAPS (TAPS),
		.AW   (AW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept),
		.start_ptr   (pos_q),
		.fill        (fill_q),
		.busy        (seq_busy),
		.last_issued (last_issued),
		.rd_addr     (rd_addr),
		.rd_en       (rd_en),
		.ctl_s1      (ctl_s1),
		.coef_s1     (coef_s1)
	);

	fir_q15_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (accept),
		.ctl_s1    (ctl_s1),
		.sample_s1 (rd_data),
		.coef_s1   (coef_s1),
		.acc       (acc),
		.done      (acc_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			fill_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						pos_q   <= (pos_q == '0) ? AW'(TAPS - 1) : pos_q - AW'(1);
						if (fill_q != (AW + 1)'(TAPS)) begin
							fill_q <= fill_q + (AW + 1)'(1);
						end
					end
				end
				ST_RUN: begin
					if (last_issued) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (acc_done) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_in;
		end
		if (load_out) begin
			out_pass_q <= sample_q;
			out_filt_q <= acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall           = (state_q != ST_IDLE);
	assign out_valid          = out_valid_q;
	assign passthrough_sample = out_pass_q;
	assign filtered_sample    = out_filt_q;

`ifndef SYNTHESIS
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		acc_done |-> (state_q == ST_WAIT))
		else $error("accumulator finished outside wait state");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (AW + 1)'(TAPS))
		else $error("fill count beyond tap count");
	a_out_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_WAIT || state_q == ST_HOLD))
		else $error("output word loaded without a finished result");
	a_seq_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		seq_busy |-> (state_q == ST_RUN))
		else $error("taps issuing outside run state");
`endif

endmodule

// ----- design/fir_q15_dly.sv -----
// Delay line storage for the Q15 FIR filter: one write port, one registered read port.
// Depends on nothing beyond its parameters.
module fir_q15_dly #(
	parameter int DEPTH = 401,
	parameter int AW    = 9
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_data
);

	logic [15:0] mem_q [0:DEPTH-1];
	logic [15:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/fir_q15_mac.sv -----
// Shared Q15 multiply and saturating accumulate unit, two register stages.
// Depends on fir_q15_pkg for the tap control word and the clamp function.
module fir_q15_mac (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clear,
	input  fir_q15_pkg::tap_ctl_t ctl_s1,
	input  logic [15:0]           sample_s1,
	input  logic [15:0]           coef_s1,
	output logic [15:0]           acc,
	output logic                  done
);
	import fir_q15_pkg::*;

	logic signed [15:0] mul_a;
	logic signed [31:0] prod_s2;
	tap_ctl_t           ctl_s2;
	word_t              prod_sat;
	logic [16:0]        sum;
	word_t              acc_q;
	logic               done_q;

	// Drop samples from slots not yet written since reset.
	assign mul_a = ctl_s1.live ? $signed(sample_s1) : 16'sd0;

	always_ff @(posedge clk) begin
		prod_s2 <= mul_a * $signed(coef_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	assign prod_sat = sat16(prod_s2[31:15]);
	assign sum      = {acc_q[15], acc_q} + {prod_sat[15], prod_sat};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s2.valid & ctl_s2.last;
			if (clear) begin
				acc_q <= '0;
			end else if (ctl_s2.valid) begin
				acc_q <= sat16(sum);
			end
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

// ----- design/fir_q15_filter_top_note.sv -----
// Tap sequencer for the Q15 FIR filter: walks the delay line and coefficient table.
// Depends on fir_q15_pkg for the coefficient function and the tap control word.
module fir_q15_seq #(
	parameter int TAPS = 401,
	parameter int AW   = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [AW-1:0]         start_ptr,
	input  logic [AW:0]           fill,
	output logic                  busy,
	output logic                  last_issued,
	output logic [AW-1:0]         rd_addr,
	output logic                  rd_en,
	output fir_q15_pkg::tap_ctl_t ctl_s1,
	output logic [15:0]           coef_s1
);
	import fir_q15_pkg::*;

	logic [AW-1:0] tap_q;
	logic [AW-1:0] rd_ptr_q;
	logic          run_q;
	tap_ctl_t      ctl_q;
	word_t         coef_q;
	logic          last_tap;

	assign last_tap = (tap_q == AW'(TAPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			tap_q    <= '0;
			rd_ptr_q <= '0;
			ctl_q    <= '0;
		end else begin
			ctl_q <= '0;
			if (start) begin
				run_q    <= 1'b1;
				tap_q    <= '0;
				rd_ptr_q <= start_ptr;
			end else if (run_q) begin
				ctl_q.valid <= 1'b1;
				ctl_q.last  <= last_tap;
				ctl_q.live  <= ({1'b0, tap_q} < fill);
				rd_ptr_q    <= (rd_ptr_q == AW'(TAPS - 1)) ? '0 : rd_ptr_q + AW'(1);
				if (last_tap) begin
					run_q <= 1'b0;
				end else begin
					tap_q <= tap_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_q) begin
			coef_q <= coef_at(COEF_IDX_W'(tap_q));
		end
	end

	assign busy        = run_q;
	assign last_issued = run_q & last_tap;
	assign rd_addr     = rd_ptr_q;
	assign rd_en       = run_q;
	assign ctl_s1      = ctl_q;
	assign coef_s1     = coef_q;

`ifndef SYNTHESIS
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(tap_q <= AW'(TAPS - 1)) && (rd_ptr_q <= AW'(TAPS - 1)))
		else $error("tap or read pointer out of range");
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q && last_tap && !start) |=> !run_q && ctl_q.valid && ctl_q.last)
		else $error("run did not end on last tap");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !run_q)
		else $error("start while taps still issuing");
`endif

endmodule
